/* rtl/pwac_pkg.sv */
// ----------------------------------------------------------------------------
// pwac_pkg
// Shared types and constants for the wheel angle pid controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pwac_pkg;

    localparam int IN_W       = 24;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int ERR_W = 30;
    localparam int DER_W = 31;
    localparam int SUM_W = 48;
    localparam int SUM_SPLIT = 24;

    localparam int ANG_MAG_W = 28;
    localparam int REF_MAG_W = 27;
    localparam int ANG_Q_W   = 21;
    localparam int REF_Q_W   = 25;
    localparam int RECIP_SHIFT = 32;
    localparam int ANG_K_W   = 26;
    localparam int REF_K_W   = 31;

    localparam logic [ANG_K_W-1:0] ANG_RECIP = 26'd34359738;
    localparam logic [REF_K_W-1:0] REF_RECIP = 31'd1431655765;
    localparam logic [6:0]         ANG_DIV   = 7'd125;
    localparam logic [1:0]         REF_DIV   = 2'd3;
    localparam int ANG_SCALE_SH = 8;

    localparam int P_KP_W  = GAIN_W + ERR_W;
    localparam int P_KD_W  = GAIN_W + DER_W;
    localparam int P_ILO_W = GAIN_W + SUM_SPLIT + 1;
    localparam int P_IHI_W = GAIN_W + SUM_W - SUM_SPLIT;
    localparam int ACC_W   = 82;
    localparam int DRIVE_SHIFT = 25;
    localparam int V_W     = ACC_W - DRIVE_SHIFT;

    localparam logic signed [GAIN_W-1:0] KP_RESET = 32'sd5153960;
    localparam logic signed [GAIN_W-1:0] KI_RESET = 32'sd6442;
    localparam logic signed [GAIN_W-1:0] KD_RESET = 32'sd0;
    localparam logic [LIM_W-1:0]         LIM_RESET = 15'd21299;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN     = 2'd0,
        REG_KI_GAIN     = 2'd1,
        REG_KD_GAIN     = 2'd2,
        REG_DRIVE_LIMIT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [IN_W-1:0] encoder_count;
        logic signed [IN_W-1:0] setpoint_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } t_out_word;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] ki_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [LIM_W-1:0]         drive_limit;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [DER_W-1:0] deriv;
        logic signed [SUM_W-1:0] error_sum;
    } t_err_word;

endpackage

`default_nettype wire

/* rtl/pwac_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pwac_cfg_regs
// Gain and drive limit registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwac_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pwac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pwac_pkg::t_gains                      o_gains
);

    pwac_pkg::t_gains r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp_gain     <= pwac_pkg::KP_RESET;
            r_gains.ki_gain     <= pwac_pkg::KI_RESET;
            r_gains.kd_gain     <= pwac_pkg::KD_RESET;
            r_gains.drive_limit <= pwac_pkg::LIM_RESET;
        end else if (i_cfg_we) begin
            unique case (pwac_pkg::t_cfg_reg'(i_cfg_index))
                pwac_pkg::REG_KP_GAIN: begin
                    r_gains.kp_gain <= $signed(i_cfg_data[pwac_pkg::GAIN_W-1:0]);
                end
                pwac_pkg::REG_KI_GAIN: begin
                    r_gains.ki_gain <= $signed(i_cfg_data[pwac_pkg::GAIN_W-1:0]);
                end
                pwac_pkg::REG_KD_GAIN: begin
                    r_gains.kd_gain <= $signed(i_cfg_data[pwac_pkg::GAIN_W-1:0]);
                end
                pwac_pkg::REG_DRIVE_LIMIT: begin
                    r_gains.drive_limit <= i_cfg_data[pwac_pkg::LIM_W-1:0];
                end
                default: begin
                    r_gains <= r_gains;
                end
            endcase
        end
    end

    assign o_gains = r_gains;

endmodule

`default_nettype wire

/* rtl/pwac_err_stage.sv */
// ----------------------------------------------------------------------------
// pwac_err_stage
// Angle conversion, error, saturating error sum and derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module pwac_err_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire pwac_pkg::t_in_word   i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output pwac_pkg::t_err_word       o_word
);

    localparam int AW = pwac_pkg::ANG_MAG_W;
    localparam int RW = pwac_pkg::REF_MAG_W;
    localparam int AQ = pwac_pkg::ANG_Q_W;
    localparam int RQ = pwac_pkg::REF_Q_W;
    localparam int EW = pwac_pkg::ERR_W;
    localparam int DW = pwac_pkg::DER_W;
    localparam int SW = pwac_pkg::SUM_W;
    localparam int IW = pwac_pkg::IN_W;
    localparam int KS = pwac_pkg::RECIP_SHIFT;

    // input register
    logic               r_in_v;
    pwac_pkg::t_in_word r_in_word;

    // quotient estimate stage
    logic               r_q_v;
    logic               r_q_cnt_neg;
    logic               r_q_ref_neg;
    logic [AW-1:0]      r_q_m;
    logic [RW-1:0]      r_q_n;
    logic [AQ-1:0]      r_q_qa;
    logic [RQ-1:0]      r_q_qr;

    // error stage
    logic                r_v;
    pwac_pkg::t_err_word r_word;
    logic signed [SW-1:0] r_error_sum;
    logic signed [EW-1:0] r_last_error;

    logic en0;
    logic enA;
    logic enB;

    logic [IW-1:0]                cnt_mag;
    logic [IW-1:0]                ref_mag;
    logic [AW-1:0]                m;
    logic [RW-1:0]                n;
    logic [AW+pwac_pkg::ANG_K_W-1:0] prod_a;
    logic [RW+pwac_pkg::REF_K_W-1:0] prod_r;

    logic [AW-1:0]        rem_a;
    logic [RW-1:0]        rem_r;
    logic [AQ-1:0]        q_a;
    logic [RQ-1:0]        q_r;
    logic signed [EW-1:0] actual;
    logic signed [EW-1:0] target;
    logic signed [EW-1:0] err;
    logic signed [SW:0]   sum_ext;
    logic signed [SW-1:0] n_error_sum;
    logic signed [DW-1:0] deriv;

    assign enB     = !r_v || i_ready;
    assign enA     = !r_q_v || enB;
    assign en0     = !r_in_v || enA;
    assign o_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en0) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0 && i_valid) begin
            r_in_word <= i_word;
        end
    end

    // magnitudes, scale by 18 and 11, reciprocal multiply
    always_comb begin
        cnt_mag = r_in_word.encoder_count[IW-1] ? IW'(-r_in_word.encoder_count)
                                                : IW'(r_in_word.encoder_count);
        ref_mag = r_in_word.setpoint_angle[IW-1] ? IW'(-r_in_word.setpoint_angle)
                                                 : IW'(r_in_word.setpoint_angle);
        m = {cnt_mag, 4'b0} + AW'({cnt_mag, 1'b0});
        n = RW'({ref_mag, 3'b0}) + RW'({ref_mag, 1'b0}) + RW'(ref_mag);
        prod_a = (AW+pwac_pkg::ANG_K_W)'(m) * (AW+pwac_pkg::ANG_K_W)'(pwac_pkg::ANG_RECIP);
        prod_r = (RW+pwac_pkg::REF_K_W)'(n) * (RW+pwac_pkg::REF_K_W)'(pwac_pkg::REF_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (enA) begin
            r_q_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enA && r_in_v) begin
            r_q_cnt_neg <= r_in_word.encoder_count[IW-1];
            r_q_ref_neg <= r_in_word.setpoint_angle[IW-1];
            r_q_m       <= m;
            r_q_n       <= n;
            r_q_qa      <= prod_a[KS+AQ-1:KS];
            r_q_qr      <= prod_r[KS+RQ-1:KS];
        end
    end

    // quotient correction, error, sum and derivative
    always_comb begin
        rem_a  = r_q_m - AW'(AW'(r_q_qa) * AW'(pwac_pkg::ANG_DIV));
        rem_r  = r_q_n - RW'(RW'(r_q_qr) * RW'(pwac_pkg::REF_DIV));
        q_a    = (rem_a >= AW'(pwac_pkg::ANG_DIV)) ? r_q_qa + AQ'(1) : r_q_qa;
        q_r    = (rem_r >= RW'(pwac_pkg::REF_DIV)) ? r_q_qr + RQ'(1) : r_q_qr;
        actual = r_q_cnt_neg ? -$signed(EW'({q_a, {pwac_pkg::ANG_SCALE_SH{1'b0}}}))
                             :  $signed(EW'({q_a, {pwac_pkg::ANG_SCALE_SH{1'b0}}}));
        target = r_q_ref_neg ? -$signed(EW'(q_r)) : $signed(EW'(q_r));
        err    = target - actual;
        sum_ext = {r_error_sum[SW-1], r_error_sum}
                + {{(SW+1-EW){err[EW-1]}}, err};
        if (sum_ext[SW] != sum_ext[SW-1]) begin
            n_error_sum = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            n_error_sum = sum_ext[SW-1:0];
        end
        deriv = {err[EW-1], err} - {r_last_error[EW-1], r_last_error};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v          <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (enB) begin
            r_v <= r_q_v;
            if (r_q_v) begin
                r_error_sum  <= n_error_sum;
                r_last_error <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enB && r_q_v) begin
            r_word.err       <= err;
            r_word.deriv     <= deriv;
            r_word.error_sum <= n_error_sum;
        end
    end

    assign o_valid = r_v;
    assign o_word  = r_word;

endmodule

`default_nettype wire

/* rtl/pwac_mix_stage.sv */
// ----------------------------------------------------------------------------
// pwac_mix_stage
// Gain products, weighted sum, shift to q1.15 and symmetric clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module pwac_mix_stage (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pwac_pkg::t_gains     i_gains,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire pwac_pkg::t_err_word  i_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output pwac_pkg::t_out_word       o_word
);

    localparam int KPW = pwac_pkg::P_KP_W;
    localparam int KDW = pwac_pkg::P_KD_W;
    localparam int ILW = pwac_pkg::P_ILO_W;
    localparam int IHW = pwac_pkg::P_IHI_W;
    localparam int AW  = pwac_pkg::ACC_W;
    localparam int VW  = pwac_pkg::V_W;
    localparam int SP  = pwac_pkg::SUM_SPLIT;
    localparam int SW  = pwac_pkg::SUM_W;
    localparam int DRW = pwac_pkg::DRIVE_W;
    localparam int LW  = pwac_pkg::LIM_W;

    logic                  r_p_v;
    logic signed [KPW-1:0] r_p_kp;
    logic signed [KDW-1:0] r_p_kd;
    logic signed [ILW-1:0] r_p_ilo;
    logic signed [IHW-1:0] r_p_ihi;

    logic                  r_s_v;
    logic signed [VW-1:0]  r_s_val;

    logic                  r_o_v;
    pwac_pkg::t_out_word   r_o_word;

    logic enC;
    logic enD;
    logic enE;

    logic signed [KPW-1:0] p_kp;
    logic signed [KDW-1:0] p_kd;
    logic signed [ILW-1:0] p_ilo;
    logic signed [IHW-1:0] p_ihi;
    logic signed [AW-1:0]  acc;
    logic signed [VW-1:0]  lim_pos;
    logic signed [VW-1:0]  lim_neg;
    pwac_pkg::t_out_word   n_word;

    assign enE     = !r_o_v || i_ready;
    assign enD     = !r_s_v || enE;
    assign enC     = !r_p_v || enD;
    assign o_ready = enC;

    always_comb begin
        p_kp  = $signed(i_gains.kp_gain) * $signed(i_word.err);
        p_kd  = $signed(i_gains.kd_gain) * $signed(i_word.deriv);
        p_ilo = $signed(i_gains.ki_gain) * $signed({1'b0, i_word.error_sum[SP-1:0]});
        p_ihi = $signed(i_gains.ki_gain) * $signed(i_word.error_sum[SW-1:SP]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (enC) begin
            r_p_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enC && i_valid) begin
            r_p_kp  <= p_kp;
            r_p_kd  <= p_kd;
            r_p_ilo <= p_ilo;
            r_p_ihi <= p_ihi;
        end
    end

    // weighted sum, arithmetic shift right
    always_comb begin
        acc = {{(AW-KPW){r_p_kp[KPW-1]}}, r_p_kp}
            + {{(AW-KDW){r_p_kd[KDW-1]}}, r_p_kd}
            + {{(AW-ILW){r_p_ilo[ILW-1]}}, r_p_ilo}
            + {{(AW-IHW-SP){r_p_ihi[IHW-1]}}, r_p_ihi, {SP{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (enD) begin
            r_s_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enD && r_p_v) begin
            r_s_val <= acc[AW-1:pwac_pkg::DRIVE_SHIFT];
        end
    end

    // symmetric clamp
    always_comb begin
        lim_pos = $signed({{(VW-LW){1'b0}}, i_gains.drive_limit});
        lim_neg = -lim_pos;
        if (r_s_val > lim_pos) begin
            n_word.drive   = lim_pos[DRW-1:0];
            n_word.clamped = 1'b1;
        end else if (r_s_val < lim_neg) begin
            n_word.drive   = lim_neg[DRW-1:0];
            n_word.clamped = 1'b1;
        end else begin
            n_word.drive   = r_s_val[DRW-1:0];
            n_word.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (enE) begin
            r_o_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enE && r_s_v) begin
            r_o_word <= n_word;
        end
    end

    assign o_valid = r_o_v;
    assign o_word  = r_o_word;

endmodule

`default_nettype wire

/* rtl/pid_wheel_angle_controller.sv */
// ----------------------------------------------------------------------------
// pid_wheel_angle_controller
// Wheel angle pid loop with saturating error sum and clamped q1.15 drive.
// ----------------------------------------------------------------------------
// pass: a word moves through the input, quotient, error, product, sum and output registers in order
// throughput: one word per cycle while the output is not stalled, through the six register stages of the pass
// output stall: stages with a free slot keep taking words until all are full
// reset: gains and drive limit return to their defaults, error sum and last
// error clear to zero, all stages empty
`default_nettype none

module pid_wheel_angle_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire pwac_pkg::t_in_word               i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output pwac_pkg::t_out_word                   o_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [pwac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pwac_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pwac_pkg::t_gains    gains;
    pwac_pkg::t_err_word err_word;
    logic                err_valid;
    logic                err_ready;

    pwac_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gains     (gains)
    );

    pwac_err_stage u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (err_valid),
        .i_ready (err_ready),
        .o_word  (err_word)
    );

    pwac_mix_stage u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (gains),
        .i_valid (err_valid),
        .o_ready (err_ready),
        .i_word  (err_word),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire
